// File: rtl/irc_tok_pkg.sv
package irc_tok_pkg;

   // Result kinds
   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_TOKEN_END = 2'd1;
   localparam logic [1:0] KIND_MSG_END   = 2'd2;

   // Protocol bytes
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Result queue geometry
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PW    = 2;   // pointer width
   localparam int OUTQ_CW    = 3;   // fill count width, holds OUTQ_DEPTH

   // One result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [3:0] token_index;
      logic       in_trailing;
      logic       last;
   } rsp_item_type;

endpackage

// File: rtl/irc_tok_engine.sv
module irc_tok_engine
   import irc_tok_pkg::*;
#(
   parameter int MAX_TOKENS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   data_byte,
   output logic [1:0]   res_count,
   output rsp_item_type res0,
   output rsp_item_type res1
);

   localparam int CW = $clog2(MAX_TOKENS);
   localparam int IW = (CW > 4) ? CW : 4;

   typedef struct packed {
      logic          in_params;
      logic          cr_pending;
      logic          token_nonempty;
      logic          trailing_mode;
      logic [CW-1:0] token_count;
   } tok_state_type;

   typedef struct packed {
      tok_state_type st;
      logic          emit;
      rsp_item_type  item;
   } feed_out_type;

   localparam tok_state_type STATE_RESET = '0;

   tok_state_type state_ff, state_in;

   function automatic logic [3:0] cap_index(input logic [CW-1:0] cnt);
      logic [IW-1:0] ext;
      ext = IW'(cnt);
      if (ext > IW'(15))
         return 4'd15;
      return ext[3:0];
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
   endfunction

   function automatic rsp_item_type make_item(input logic [1:0] kind,
                                              input logic [7:0] ch,
                                              input logic [3:0] idx,
                                              input logic trail);
      rsp_item_type it;
      it.kind        = kind;
      it.char_out    = ch;
      it.token_index = idx;
      it.in_trailing = trail;
      it.last        = 1'b0;
      return it;
   endfunction

   // Handle one byte as character or separator
   function automatic feed_out_type feed(input tok_state_type s,
                                         input logic [7:0] c,
                                         input logic ws);
      feed_out_type f;
      f.st   = s;
      f.emit = 1'b0;
      f.item = make_item(KIND_CHAR, c, cap_index(s.token_count), 1'b0);
      if (s.trailing_mode) begin
         f.emit                = 1'b1;
         f.item.in_trailing    = 1'b1;
         f.st.token_nonempty   = 1'b1;
      end else if (s.in_params && c == CH_COLON && !s.token_nonempty) begin
         f.st.trailing_mode = 1'b1;
      end else if (!ws) begin
         f.emit              = 1'b1;
         f.st.token_nonempty = 1'b1;
      end else if (s.token_nonempty) begin
         // close the token and advance the saturating index
         f.emit = 1'b1;
         f.item = make_item(KIND_TOKEN_END, 8'd0, cap_index(s.token_count), 1'b0);
         if (s.token_count < CW'(MAX_TOKENS - 1))
            f.st.token_count = s.token_count + CW'(1);
         f.st.token_nonempty = 1'b0;
         f.st.in_params      = 1'b1;
      end
      return f;
   endfunction

   feed_out_type  f1, f2;
   tok_state_type s1;
   logic          crlf;

   // Resolve a pending CR, then the new byte
   always_comb begin
      crlf      = state_ff.cr_pending && data_byte == CH_LF;
      s1        = state_ff;
      s1.cr_pending = 1'b0;
      f1        = '0;
      f2        = '0;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;
      state_in  = state_ff;
      if (crlf) begin
         state_in = STATE_RESET;
         if (state_ff.token_nonempty || state_ff.trailing_mode) begin
            res0 = make_item(KIND_TOKEN_END, 8'd0, cap_index(state_ff.token_count),
                             state_ff.trailing_mode);
            res1 = make_item(KIND_MSG_END, 8'd0, 4'd0, 1'b0);
            res_count = 2'd2;
         end else begin
            res0 = make_item(KIND_MSG_END, 8'd0, 4'd0, 1'b0);
            res_count = 2'd1;
         end
      end else begin
         if (state_ff.cr_pending) begin
            f1 = feed(s1, CH_CR, 1'b1);
         end else begin
            f1.st = s1;
         end
         if (data_byte == CH_CR) begin
            f2.st            = f1.st;
            f2.st.cr_pending = 1'b1;
         end else begin
            f2 = feed(f1.st, data_byte, is_ws(data_byte));
         end
         state_in = f2.st;
         if (f1.emit) begin
            res0      = f1.item;
            res1      = f2.item;
            res_count = f2.emit ? 2'd2 : 2'd1;
         end else begin
            res0      = f2.item;
            res_count = {1'b0, f2.emit};
         end
      end
      // mark the final result of this byte
      res0.last = (res_count == 2'd1);
      res1.last = 1'b1;
   end

   // Hold tokenizer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/irc_tok_outq.sv
module irc_tok_outq
   import irc_tok_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  rsp_item_type       push0,
   input  rsp_item_type       push1,
   input  logic               pop,
   output logic               nonempty,
   output rsp_item_type       head,
   output logic [OUTQ_CW-1:0] free_count
);

   rsp_item_type         entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CW-1:0]   count_ff, count_in;
   logic                 do_pop;

   assign nonempty   = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign free_count = OUTQ_CW'(OUTQ_DEPTH) - count_ff;
   assign do_pop     = pop && nonempty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_PW'(push_count);
      rd_ptr_in = rd_ptr_ff + OUTQ_PW'(do_pop);
      count_in  = count_ff + OUTQ_CW'(push_count) - OUTQ_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store up to two results per cycle
   always_ff @(posedge clock) begin
      if (push_count != 2'd0)
         entry_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2)
         entry_ff[wr_ptr_ff + OUTQ_PW'(1)] <= push1;
   end

endmodule

// File: rtl/irc_line_tokenizer_unit.sv
// Channel | Dir | Handshake             | Contents
// req     | in  | req_tvalid/req_tready | tdata: data_byte[7:0]
// rsp     | out | rsp_tvalid/rsp_tready | tdata: char_out, token_index, in_trailing;
//         |     |                       | tuser: kind; tlast: last
//
// One byte per cycle is taken into the input register while req_tready is
// high. The held byte is resolved into 0, 1 or 2 results written to a
// four-entry result queue. The queue space check (room for all results of
// the held byte) decides when the input register drains. Reset is
// synchronous and returns the tokenizer to the start of a message. A stalled
// rsp side fills the queue, then holds req_tready low.
module irc_line_tokenizer_unit
   import irc_tok_pkg::*;
#(
   parameter int MAX_TOKENS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_out, [11:8] token_index,
                                    // [12] in_trailing, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               fire, req_take;
   logic [1:0]         res_count;
   rsp_item_type       res0, res1, head;
   logic [OUTQ_CW-1:0] free_count;

   assign fire       = in_valid_ff && (free_count >= OUTQ_CW'(res_count));
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !fire);

   // Hold the accepted request byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_byte_ff <= req_tdata;
   end

   irc_tok_engine #(
      .MAX_TOKENS(MAX_TOKENS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   irc_tok_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_count (fire ? res_count : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop        (rsp_tready),
      .nonempty   (rsp_tvalid),
      .head       (head),
      .free_count (free_count)
   );

   // Pack the result fields
   assign rsp_tdata = {3'b000, head.in_trailing, head.token_index, head.char_out};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
